// ===== rtl/gatl_pkg.sv =====
// Shared types, codes and helpers for the glyph atlas text layout block.
`default_nettype none

package gatl_pkg;

	// Command codes carried by an input beat.
	localparam logic [1:0] CMD_SET   = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_TEXT  = 2'd2;

	// Status codes carried by a result beat.
	localparam logic [1:0] ST_DRAW      = 2'd0;
	localparam logic [1:0] ST_BAD_TEXT  = 2'd1;
	localparam logic [1:0] ST_BAD_GLYPH = 2'd2;

	// Character codes with a meaning of their own.
	localparam logic [7:0] CODE_FIRST   = 8'd32;
	localparam logic [7:0] CODE_LAST    = 8'd126;
	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_END     = 8'd0;

	// One glyph rectangle in the atlas.
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [7:0]         w;
		logic [7:0]         h;
	} glyph_entry_t;

	// Adds an unsigned step to a signed coordinate, clamping at the positive limit.
	// The step is never negative, so only positive overflow can occur.
	function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
		input logic [7:0] b);
		logic [16:0] sum;
		sum = {a[15], a} + {9'd0, b};
		if (sum[16] != sum[15]) begin
			return 16'sh7FFF;
		end
		return sum[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gatl_req_if.sv =====
// Input channel: one command beat with its payload.
`default_nettype none

interface gatl_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [7:0]         char_code;
	logic signed [15:0] rect_x;
	logic signed [15:0] rect_y;
	logic [7:0]         rect_w;
	logic [7:0]         rect_h;

	modport source (output valid, cmd, char_code, rect_x, rect_y, rect_w, rect_h,
		input ready);
	modport sink (input valid, cmd, char_code, rect_x, rect_y, rect_w, rect_h,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/gatl_rsp_if.sv =====
// Output channel: one copy command or error beat.
`default_nettype none

interface gatl_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [15:0] src_x;
	logic signed [15:0] src_y;
	logic [7:0]         glyph_w;
	logic [7:0]         glyph_h;
	logic signed [15:0] dest_x;
	logic signed [15:0] dest_y;

	modport source (output valid, status, src_x, src_y, glyph_w, glyph_h, dest_x, dest_y,
		input ready);
	modport sink (input valid, status, src_x, src_y, glyph_w, glyph_h, dest_x, dest_y,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/gatl_glyph_mem.sv =====
// Glyph rectangle memory with per-entry valid bits and a registered read port.
`default_nettype none

module gatl_glyph_mem #(
	parameter int GLYPH_COUNT = 95,
	parameter int IDX_W       = 7
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         wr_en,
	input  wire [IDX_W-1:0]             wr_idx,
	input  wire gatl_pkg::glyph_entry_t wr_data,
	input  wire                         rd_en,
	input  wire [IDX_W-1:0]             rd_idx,
	output gatl_pkg::glyph_entry_t      rd_data
);
	import gatl_pkg::*;

	glyph_entry_t           mem [GLYPH_COUNT];
	logic [GLYPH_COUNT-1:0] written_q;
	glyph_entry_t           rd_data_q;
	logic                   rd_written_q;

	// Storage array; entries hold garbage until written.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	// Valid bits mark written entries and clear at once on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_idx];
			end
		end
	end

	// An entry never written reads as an all-zero rectangle.
	assign rd_data = rd_written_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== rtl/glyph_atlas_text_layout_unit.sv =====
// A result beat is registered in stage one at accept and then in the output register.
// Throughput: one input beat per cycle while stage one does not stall; the glyph memory
// read at accept time and the cursor update as stage one retires set that figure.
// While a result waits in the output register, input beats keep flowing until another
// beat that has a result reaches stage one; that beat then stalls the input.
// Reset clears the cursor, origin, tallest height, end-of-string flag and output valid;
// the glyph table reads as all zero until each entry is written.
`default_nettype none

module glyph_atlas_text_layout_unit #(
	parameter int GLYPH_COUNT = 95
) (
	input wire         clk,
	input wire         arst_n,
	gatl_req_if.sink   req,
	gatl_rsp_if.source rsp
);
	import gatl_pkg::*;

	localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

	// Input decode of the glyph code.
	logic [7:0]       code_off;
	logic             code_ok;
	logic [IDX_W-1:0] code_idx;
	logic             accept;
	logic             mem_wr;
	glyph_entry_t     wr_entry;
	glyph_entry_t     rd_entry;

	// Stage one registers.
	logic               vld_s1;
	logic [1:0]         cmd_s1;
	logic               ok_s1;
	logic               is_end_s1;
	logic               is_nl_s1;
	logic signed [15:0] rx_s1;
	logic signed [15:0] ry_s1;
	logic [7:0]         rh_s1;

	// Layout state.
	logic signed [15:0] cur_x_q;
	logic signed [15:0] cur_y_q;
	logic signed [15:0] org_x_q;
	logic [7:0]         tall_q;
	logic               ended_q;

	// Output register.
	logic               rsp_valid_q;
	logic [1:0]         status_q;
	glyph_entry_t       src_q;
	logic signed [15:0] dest_x_q;
	logic signed [15:0] dest_y_q;

	// Next-state and result of the item in stage one.
	logic               has_res;
	logic [1:0]         res_status;
	glyph_entry_t       res_src;
	logic signed [15:0] nxt_x;
	logic signed [15:0] nxt_y;
	logic signed [15:0] nxt_org;
	logic [7:0]         nxt_tall;
	logic               nxt_ended;
	logic               s1_fire;

	assign code_off = req.char_code - CODE_FIRST;
	assign code_ok  = (req.char_code inside {[CODE_FIRST:CODE_LAST]}) &&
		({1'b0, code_off} < 9'(GLYPH_COUNT));
	assign code_idx = code_ok ? code_off[IDX_W-1:0] : '0;

	assign accept   = req.valid && req.ready;
	assign mem_wr   = accept && (req.cmd == CMD_SET) && code_ok;
	assign wr_entry = '{x: req.rect_x, y: req.rect_y, w: req.rect_w, h: req.rect_h};

	// The table is written and read at accept, so a later item sees every earlier write.
	gatl_glyph_mem #(
		.GLYPH_COUNT(GLYPH_COUNT),
		.IDX_W      (IDX_W)
	) u_glyph_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (mem_wr),
		.wr_idx (code_idx),
		.wr_data(wr_entry),
		.rd_en  (accept),
		.rd_idx (code_idx),
		.rd_data(rd_entry)
	);

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (s1_fire) begin
			vld_s1 <= 1'b0;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= req.cmd;
			ok_s1     <= code_ok;
			is_end_s1 <= (req.char_code == CODE_END);
			is_nl_s1  <= (req.char_code == CODE_NEWLINE);
			rx_s1     <= req.rect_x;
			ry_s1     <= req.rect_y;
			rh_s1     <= req.rect_h;
		end
	end

	// Command decode, cursor arithmetic and result selection.
	always_comb begin
		has_res    = 1'b0;
		res_status = ST_DRAW;
		res_src    = '0;
		nxt_x      = cur_x_q;
		nxt_y      = cur_y_q;
		nxt_org    = org_x_q;
		nxt_tall   = tall_q;
		nxt_ended  = ended_q;
		case (cmd_s1)
			CMD_SET: begin
				if (!ok_s1) begin
					has_res    = 1'b1;
					res_status = ST_BAD_GLYPH;
				end else if (rh_s1 > tall_q) begin
					nxt_tall = rh_s1;
				end
			end
			CMD_START: begin
				nxt_x     = rx_s1;
				nxt_y     = ry_s1;
				nxt_org   = rx_s1;
				nxt_ended = 1'b0;
			end
			CMD_TEXT: begin
				if (!ended_q) begin
					if (is_end_s1) begin
						nxt_ended = 1'b1;
					end else if (is_nl_s1) begin
						nxt_y = sat_add16(cur_y_q, tall_q);
						nxt_x = org_x_q;
					end else if (!ok_s1) begin
						has_res    = 1'b1;
						res_status = ST_BAD_TEXT;
					end else begin
						has_res = 1'b1;
						res_src = rd_entry;
						nxt_x   = sat_add16(cur_x_q, rd_entry.w);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Stage one moves on unless its result has nowhere to go.
	assign s1_fire   = vld_s1 && (!has_res || !rsp_valid_q || rsp.ready);
	assign req.ready = !vld_s1 || s1_fire;

	// Layout state commits as the stage one item retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			org_x_q <= '0;
			tall_q  <= '0;
			ended_q <= 1'b0;
		end else if (s1_fire) begin
			cur_x_q <= nxt_x;
			cur_y_q <= nxt_y;
			org_x_q <= nxt_org;
			tall_q  <= nxt_tall;
			ended_q <= nxt_ended;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire && has_res) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output payload; the cursor is shown only on a draw command.
	always_ff @(posedge clk) begin
		if (s1_fire && has_res) begin
			status_q <= res_status;
			src_q    <= res_src;
			dest_x_q <= (res_status == ST_DRAW) ? cur_x_q : '0;
			dest_y_q <= (res_status == ST_DRAW) ? cur_y_q : '0;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = status_q;
	assign rsp.src_x   = src_q.x;
	assign rsp.src_y   = src_q.y;
	assign rsp.glyph_w = src_q.w;
	assign rsp.glyph_h = src_q.h;
	assign rsp.dest_x  = dest_x_q;
	assign rsp.dest_y  = dest_y_q;

endmodule

`default_nettype wire

// ===== rtl/gatl_checker.sv =====
// Port-level checks for the glyph atlas text layout block, bound to the top level.
`default_nettype none

module gatl_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        req_valid,
	input wire        req_ready,
	input wire        rsp_valid,
	input wire        rsp_ready,
	input wire [1:0]  status,
	input wire [15:0] src_x,
	input wire [15:0] src_y,
	input wire [7:0]  glyph_w,
	input wire [7:0]  glyph_h,
	input wire [15:0] dest_x,
	input wire [15:0] dest_y
);
	import gatl_pkg::*;

	// A stalled result beat keeps its status, source x and destination.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(src_x) &&
			$stable(dest_x) && $stable(dest_y))
		else $error("result beat changed while stalled");

	// Status is one of the three defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_DRAW || status == ST_BAD_TEXT || status == ST_BAD_GLYPH))
		else $error("undefined status code");

	// Error beats carry all-zero rectangles.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_DRAW |-> src_x == '0 && src_y == '0 &&
			glyph_w == '0 && glyph_h == '0 && dest_x == '0 && dest_y == '0)
		else $error("error beat with nonzero fields");

	// A result appearing on an empty output comes from an earlier accepted input beat.
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("result beat without a matching input beat");

endmodule

bind glyph_atlas_text_layout_unit gatl_checker u_gatl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status   (rsp.status),
	.src_x    (rsp.src_x),
	.src_y    (rsp.src_y),
	.glyph_w  (rsp.glyph_w),
	.glyph_h  (rsp.glyph_h),
	.dest_x   (rsp.dest_x),
	.dest_y   (rsp.dest_y)
);

`default_nettype wire
